// ===== rtl/swd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the LIFO stack with delete-by-value.
// Used by swd_seq, stack_with_delete_by_value_unit, stack_result_checker and the testbench; no dependencies.
package swd_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int DATA_W      = 32;
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int CMD_W       = 2;
  localparam int OUT_CNT_W   = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_DEL  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic              valid;
    status_e           status;
    logic [CNT_W-1:0]  count;
    logic [DATA_W-1:0] top;
  } res_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [DATA_W-1:0] data;
  } ram_wr_t;

endpackage

// ===== rtl/swd_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependencies.
module swd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/swd_seq.sv =====
`timescale 1ns / 1ps
// Command sequencer: owns the fill count and top register, and walks the
// entry RAM with one shared compare for delete. Depends on swd_pkg.
module swd_seq import swd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  cmd_t              cmd_i,
  output logic              idle_o,
  output res_t              res_o,
  output ram_wr_t           ram_wr_o,
  output logic [IDX_W-1:0]  ram_raddr_o,
  input  logic [DATA_W-1:0] ram_rdata_i
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_SHIFT  = 4'b0100,
    S_TOPRD  = 4'b1000
  } state_e;

  state_e            st_q, st_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [DATA_W-1:0] top_q, top_d;
  logic [DATA_W-1:0] value_q, value_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  cnt_m1, cnt_m2;
  logic              match;

  assign cnt_m1 = count_q - CNT_W'(1);
  assign cnt_m2 = count_q - CNT_W'(2);
  assign match  = (ram_rdata_i == value_q);
  assign idle_o = (st_q == S_IDLE);

  always_comb begin
    st_d        = st_q;
    count_d     = count_q;
    top_d       = top_q;
    value_d     = value_q;
    idx_d       = idx_q;
    ram_wr_o    = '0;
    ram_raddr_o = idx_q - IDX_W'(1);
    res_o.valid  = 1'b0;
    res_o.status = ST_DONE;
    res_o.count  = count_q;
    res_o.top    = top_q;

    unique case (st_q)
      S_IDLE: begin
        if (start_i) begin
          value_d = cmd_i.value;
          unique case (cmd_i.cmd)
            CMD_PUSH: begin
              res_o.valid = 1'b1;
              if (count_q == CNT_W'(STACK_DEPTH)) begin
                res_o.status = ST_FULL;
              end else begin
                ram_wr_o.en   = 1'b1;
                ram_wr_o.addr = count_q[IDX_W-1:0];
                ram_wr_o.data = cmd_i.value;
                count_d       = count_q + CNT_W'(1);
                top_d         = cmd_i.value;
                res_o.count   = count_q + CNT_W'(1);
                res_o.top     = cmd_i.value;
              end
            end
            CMD_POP: begin
              if (count_q == '0) begin
                res_o.valid  = 1'b1;
                res_o.status = ST_NOT_FOUND;
              end else if (count_q == CNT_W'(1)) begin
                count_d     = '0;
                top_d       = '0;
                res_o.valid = 1'b1;
                res_o.count = '0;
                res_o.top   = '0;
              end else begin
                // The entry below the top becomes the new top.
                ram_raddr_o = cnt_m2[IDX_W-1:0];
                st_d        = S_TOPRD;
              end
            end
            CMD_DEL: begin
              if (count_q == '0) begin
                res_o.valid  = 1'b1;
                res_o.status = ST_NOT_FOUND;
              end else begin
                ram_raddr_o = cnt_m1[IDX_W-1:0];
                idx_d       = cnt_m1[IDX_W-1:0];
                st_d        = S_SEARCH;
              end
            end
            default: begin
              res_o.valid = 1'b1;
            end
          endcase
        end
      end
      S_SEARCH: begin
        // idx_q names the entry whose data is on the read port; the next
        // lower entry is fetched every cycle until a match is seen or entry 0 is checked.
        if (match) begin
          if (idx_q == cnt_m1[IDX_W-1:0]) begin
            if (idx_q == '0) begin
              count_d     = '0;
              top_d       = '0;
              res_o.valid = 1'b1;
              res_o.count = '0;
              res_o.top   = '0;
              st_d        = S_IDLE;
            end else begin
              ram_raddr_o = idx_q - IDX_W'(1);
              st_d        = S_TOPRD;
            end
          end else begin
            ram_raddr_o = idx_q + IDX_W'(1);
            st_d        = S_SHIFT;
          end
        end else if (idx_q == '0) begin
          res_o.valid  = 1'b1;
          res_o.status = ST_NOT_FOUND;
          st_d         = S_IDLE;
        end else begin
          idx_d = idx_q - IDX_W'(1);
        end
      end
      S_SHIFT: begin
        // Read data holds entry idx_q + 1; move it down one place.
        ram_wr_o.en   = 1'b1;
        ram_wr_o.addr = idx_q;
        ram_wr_o.data = ram_rdata_i;
        if (idx_q == cnt_m2[IDX_W-1:0]) begin
          count_d     = cnt_m1;
          res_o.valid = 1'b1;
          res_o.count = cnt_m1;
          st_d        = S_IDLE;
        end else begin
          idx_d       = idx_q + IDX_W'(1);
          ram_raddr_o = idx_q + IDX_W'(2);
        end
      end
      S_TOPRD: begin
        count_d     = cnt_m1;
        top_d       = ram_rdata_i;
        res_o.valid = 1'b1;
        res_o.count = cnt_m1;
        res_o.top   = ram_rdata_i;
        st_d        = S_IDLE;
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      count_q <= '0;
      top_q   <= '0;
    end else begin
      st_q    <= st_d;
      count_q <= count_d;
      top_q   <= top_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    idx_q   <= idx_d;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(STACK_DEPTH))
    else $error("fill count beyond stack depth");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && st_q == S_IDLE && cmd_i.cmd == CMD_PUSH &&
     count_q != CNT_W'(STACK_DEPTH)) |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("accepted push did not grow the stack");

  a_shift_needs_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_SHIFT |-> count_q >= CNT_W'(2))
    else $error("shift with fewer than two entries");

  a_result_ends_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |=> st_q == S_IDLE)
    else $error("sequencer busy after giving a result");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_wr_o.en |-> (st_q == S_IDLE || st_q == S_SHIFT))
    else $error("entry write outside push or shift");
`endif

endmodule

// ===== rtl/stack_with_delete_by_value_unit.sv =====
`timescale 1ns / 1ps
// Top level of the LIFO stack with delete-by-value: handshakes, result
// register and entry RAM. Depends on swd_pkg, swd_seq and swd_ram.
//
//  channel  direction  handshake                 payload
//  in       input      in_valid_i / in_stall_o   cmd_i, value_i
//  out      output     out_valid_o / out_stall_i status_o, entry_count_o, top_value_o
//
// Push and the unused command finish from idle; pop finishes from idle or through
// a top refetch. Delete on an empty stack finishes from idle; otherwise it reads
// the top entry, checks entries downward from the top, then moves each entry above
// the match down (or refetches the top); the entry RAM has a single read port.
// Reset empties the stack at once; no clearing pass is needed.
// A new beat is taken only while idle and the result register is free or
// being drained in the same cycle.
module stack_with_delete_by_value_unit import swd_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [CMD_W-1:0]            cmd_i,
  input  logic signed [DATA_W-1:0]    value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic [OUT_CNT_W-1:0]        entry_count_o,
  output logic signed [DATA_W-1:0]    top_value_o
);

  logic              idle;
  logic              start;
  logic              out_free;
  cmd_t              cmd_beat;
  res_t              res;
  ram_wr_t           ram_wr;
  logic [IDX_W-1:0]  ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic                 out_valid_q;
  logic [1:0]           status_q;
  logic [OUT_CNT_W-1:0] count_q;
  logic [DATA_W-1:0]    top_q;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !(idle && out_free);
  assign start      = in_valid_i && !in_stall_o;

  assign cmd_beat.cmd   = cmd_i;
  assign cmd_beat.value = value_i;

  swd_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .cmd_i       (cmd_beat),
    .idle_o      (idle),
    .res_o       (res),
    .ram_wr_o    (ram_wr),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  swd_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_wr.en),
    .waddr_i (ram_wr.addr),
    .wdata_i (ram_wr.data),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      status_q <= res.status;
      count_q  <= OUT_CNT_W'(res.count);
      top_q    <= res.top;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign entry_count_o = count_q;
  assign top_value_o   = top_q;

endmodule

// ===== dv/stack_result_checker.sv =====
`timescale 1ns / 1ps
// Checker for stack_with_delete_by_value_unit: watches both channels, keeps
// its own copy of the stack, predicts each result and compares it field by
// field. Depends on swd_pkg.
module stack_result_checker import swd_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic [CMD_W-1:0]         cmd_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic [1:0]               status_i,
  input  logic [OUT_CNT_W-1:0]     entry_count_i,
  input  logic signed [DATA_W-1:0] top_value_i,
  output int                       mismatch_count_o,
  output int                       pending_o
);

  typedef struct packed {
    status_e              status;
    logic [OUT_CNT_W-1:0] count;
    logic [DATA_W-1:0]    top;
  } stack_result_t;

  logic [DATA_W-1:0] shadow_entries [STACK_DEPTH];
  int                shadow_fill;
  stack_result_t     expected_results [$];

  // Applies one command to the shadow stack and returns what the block owes.
  function automatic stack_result_t apply_stack_cmd(logic [CMD_W-1:0] op,
                                                    logic [DATA_W-1:0] val);
    stack_result_t res;
    int            hit;
    res.status = ST_DONE;
    hit = -1;
    case (op)
      CMD_PUSH: begin
        if (shadow_fill >= STACK_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          shadow_entries[shadow_fill] = val;
          shadow_fill++;
        end
      end
      CMD_POP: begin
        if (shadow_fill == 0) res.status = ST_NOT_FOUND;
        else shadow_fill--;
      end
      CMD_DEL: begin
        // Scanning upward leaves the topmost match in hit.
        for (int i = 0; i < shadow_fill; i++) begin
          if (shadow_entries[i] == val) hit = i;
        end
        if (hit < 0) begin
          res.status = ST_NOT_FOUND;
        end else begin
          for (int i = hit; i < shadow_fill - 1; i++) begin
            shadow_entries[i] = shadow_entries[i + 1];
          end
          shadow_fill--;
        end
      end
      default: ;
    endcase
    res.count = shadow_fill[OUT_CNT_W-1:0];
    res.top   = (shadow_fill > 0) ? shadow_entries[shadow_fill - 1] : '0;
    return res;
  endfunction

  task automatic log_failure(string msg);
    mismatch_count_o++;
    if (mismatch_count_o <= 10) $display("[%0t] %s", $realtime, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    stack_result_t exp_r;
    if (!rst_ni) begin
      shadow_fill      = 0;
      mismatch_count_o = 0;
      expected_results.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        expected_results.push_back(apply_stack_cmd(cmd_i, value_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          log_failure($sformatf("unexpected beat: status %0d count %0d top %h",
                                status_i, entry_count_i, top_value_i));
        end else begin
          exp_r = expected_results.pop_front();
          if (status_i !== exp_r.status || entry_count_i !== exp_r.count ||
              top_value_i !== exp_r.top) begin
            log_failure($sformatf(
              "mismatch: expected status %0d count %0d top %h, got %0d %0d %h",
              exp_r.status, exp_r.count, exp_r.top,
              status_i, entry_count_i, top_value_i));
          end
        end
      end
    end
    pending_o = expected_results.size();
  end

endmodule

// ===== dv/tb_stack_with_delete_by_value_unit.sv =====
`timescale 1ns / 1ps
// Testbench top for stack_with_delete_by_value_unit: clock, reset, command
// stimulus, result back-pressure and the verdict. Depends on swd_pkg, the
// block itself and stack_result_checker.
module tb_stack_with_delete_by_value_unit import swd_pkg::*;;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS    = 2000;
  localparam int PHASE_LEN       = 50;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int DRAIN_CYCLES    = 2 * STACK_DEPTH + 16;
  localparam int HOLD_OFF_AFTER  = 400;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int POOL_SIZE       = 6;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_e;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [CMD_W-1:0]         cmd = CMD_PUSH;
  logic signed [DATA_W-1:0] value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [1:0]               status;
  logic [OUT_CNT_W-1:0]     entry_count;
  logic signed [DATA_W-1:0] top_value;
  int                       mismatches;
  int                       pending;
  int                       beats_sent = 0;
  int                       cycles = 0;
  bit                       quiet = 1'b0;
  logic [DATA_W-1:0]        value_pool [POOL_SIZE];

  stack_with_delete_by_value_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .cmd_i         (cmd),
    .value_i       (value),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .status_o      (status),
    .entry_count_o (entry_count),
    .top_value_o   (top_value)
  );

  stack_result_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .cmd_i            (cmd),
    .value_i          (value),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .status_i         (status),
    .entry_count_i    (entry_count),
    .top_value_i      (top_value),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offers one command beat from a falling edge and returns at the falling
  // edge after it was taken.
  task automatic send_cmd(logic [CMD_W-1:0] op, logic [DATA_W-1:0] val);
    while (!quiet && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    cmd      <= op;
    value    <= val;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    beats_sent++;
    @(negedge clk_i);
  endtask

  // A small pool makes deletes hit often; extremes show up now and then.
  task automatic refresh_pool();
    for (int i = 0; i < POOL_SIZE; i++) begin
      case ($urandom_range(9))
        0:       value_pool[i] = 32'h8000_0000;
        1:       value_pool[i] = 32'h7FFF_FFFF;
        2:       value_pool[i] = 32'hFFFF_FFFF;
        default: value_pool[i] = $urandom;
      endcase
    end
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    if ($urandom_range(99) < 70) return value_pool[$urandom_range(POOL_SIZE - 1)];
    return $urandom;
  endfunction

  // Result side: random stalls, one long hold-off so that the block backs up.
  initial begin
    bit held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && beats_sent >= HOLD_OFF_AFTER) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        held = 1'b1;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 9);
      end
    end
  end

  initial begin
    int               issued;
    int               phase;
    int               roll;
    mix_e             mix;
    logic [CMD_W-1:0] op;
    issued = 0;
    phase  = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty stack corner cases, then extremes, duplicates and deletes at
    // the bottom, middle and top.
    send_cmd(CMD_POP, 32'h0);
    send_cmd(CMD_DEL, 32'h0);
    send_cmd(CMD_UNUSED, $urandom);
    send_cmd(CMD_PUSH, 32'h8000_0000);
    send_cmd(CMD_PUSH, 32'h7FFF_FFFF);
    send_cmd(CMD_PUSH, 32'h0000_0000);
    send_cmd(CMD_PUSH, 32'hFFFF_FFFF);
    send_cmd(CMD_UNUSED, 32'hFFFF_FFFF);
    send_cmd(CMD_DEL, 32'h8000_0000);
    send_cmd(CMD_DEL, 32'h0000_3039);
    send_cmd(CMD_PUSH, 32'h0000_0007);
    send_cmd(CMD_PUSH, 32'h0000_0007);
    send_cmd(CMD_DEL, 32'h0000_0007);
    send_cmd(CMD_DEL, 32'h7FFF_FFFF);
    send_cmd(CMD_DEL, 32'hFFFF_FFFF);
    send_cmd(CMD_POP, 32'h0);
    send_cmd(CMD_POP, 32'h0);
    send_cmd(CMD_POP, 32'h0);
    send_cmd(CMD_UNUSED, 32'h0);

    // Phases of different push/pop balance; the first one fills the stack
    // and runs into the full case.
    while (issued < RANDOM_ITEMS) begin
      refresh_pool();
      mix = (phase == 0) ? MIX_FILL : mix_e'($urandom_range(2));
      for (int k = 0; k < PHASE_LEN && issued < RANDOM_ITEMS; k++) begin
        quiet = (issued >= 900 && issued < 1200);
        roll  = $urandom_range(99);
        case (mix)
          MIX_FILL:  op = (roll < 85) ? CMD_PUSH : (roll < 93) ? CMD_DEL : CMD_POP;
          MIX_DRAIN: op = (roll < 55) ? CMD_POP : (roll < 90) ? CMD_DEL : CMD_PUSH;
          default: begin
            if (roll < 40)      op = CMD_PUSH;
            else if (roll < 60) op = CMD_POP;
            else if (roll < 96) op = CMD_DEL;
            else                op = CMD_UNUSED;
          end
        endcase
        send_cmd(op, pick_value());
        if (op != CMD_UNUSED) issued++;
      end
      phase++;
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
